### hdl/sym3_pkg.sv
`timescale 1ns / 1ps

package sym3_pkg;

   // six distinct elements of a symmetric 3x3 matrix
   localparam int NUM_LANES = 6;
   localparam int NUM_ROWS  = 3;

   localparam int LANE_00 = 0;
   localparam int LANE_01 = 1;
   localparam int LANE_02 = 2;
   localparam int LANE_11 = 3;
   localparam int LANE_12 = 4;
   localparam int LANE_22 = 5;

   // side information that travels with a transaction through the divider
   typedef struct packed {
      logic                 singular;
      logic [NUM_LANES-1:0] neg;
   } sym3_flags_type;

   // width of the divider partial remainder
   function automatic int num_width(input int w, input int f);
      int a;
      int b;
      a = 2 * w + 2 * f + 2;
      b = 4 * w + 1;
      return (a > b) ? a : b;
   endfunction

endpackage

### hdl/sym3_cof.sv
`timescale 1ns / 1ps

module sym3_cof #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] b_00,
   input  logic signed [DATA_WIDTH-1:0] b_01,
   input  logic signed [DATA_WIDTH-1:0] b_02,
   input  logic signed [DATA_WIDTH-1:0] b_11,
   input  logic signed [DATA_WIDTH-1:0] b_12,
   input  logic signed [DATA_WIDTH-1:0] b_22,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [2*DATA_WIDTH:0] cof [sym3_pkg::NUM_LANES],
   output logic signed [DATA_WIDTH-1:0] brow [sym3_pkg::NUM_ROWS]
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int CW = 2 * DATA_WIDTH + 1;
   localparam int NP = 2 * sym3_pkg::NUM_LANES;

   logic                  va_ff, vb_ff;
   logic                  rdy_a, rdy_b;
   logic signed [PW-1:0]  p_in [NP];
   logic signed [PW-1:0]  p_ff [NP];
   logic signed [DATA_WIDTH-1:0] ba_ff [sym3_pkg::NUM_ROWS];
   logic signed [CW-1:0]  c_in [sym3_pkg::NUM_LANES];
   logic signed [CW-1:0]  c_ff [sym3_pkg::NUM_LANES];
   logic signed [DATA_WIDTH-1:0] bb_ff [sym3_pkg::NUM_ROWS];

   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   // cofactor i = p[2i] - p[2i+1]
   always_comb begin
      p_in[0]  = PW'(b_11) * PW'(b_22);
      p_in[1]  = PW'(b_12) * PW'(b_12);
      p_in[2]  = PW'(b_12) * PW'(b_02);
      p_in[3]  = PW'(b_01) * PW'(b_22);
      p_in[4]  = PW'(b_01) * PW'(b_12);
      p_in[5]  = PW'(b_11) * PW'(b_02);
      p_in[6]  = PW'(b_00) * PW'(b_22);
      p_in[7]  = PW'(b_02) * PW'(b_02);
      p_in[8]  = PW'(b_02) * PW'(b_01);
      p_in[9]  = PW'(b_00) * PW'(b_12);
      p_in[10] = PW'(b_00) * PW'(b_11);
      p_in[11] = PW'(b_01) * PW'(b_01);
   end

   always_comb begin
      for (int i = 0; i < sym3_pkg::NUM_LANES; i++) begin
         c_in[i] = CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         p_ff     <= p_in;
         ba_ff[0] <= b_00;
         ba_ff[1] <= b_01;
         ba_ff[2] <= b_02;
      end
      if (rdy_b) begin
         c_ff  <= c_in;
         bb_ff <= ba_ff;
      end
   end

   assign out_valid = vb_ff;
   assign cof       = c_ff;
   assign brow      = bb_ff;

endmodule

### hdl/sym3_det.sv
`timescale 1ns / 1ps

module sym3_det #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [2*DATA_WIDTH:0]  cof [sym3_pkg::NUM_LANES],
   input  logic signed [DATA_WIDTH-1:0]  brow [sym3_pkg::NUM_ROWS],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [sym3_pkg::num_width(DATA_WIDTH, FRAC_BITS)-1:0] num [sym3_pkg::NUM_LANES],
   output logic [3*DATA_WIDTH-1:0]       dm,
   output sym3_pkg::sym3_flags_type      flags
);

   localparam int W    = DATA_WIDTH;
   localparam int CW   = 2 * W + 1;
   localparam int CMW  = 2 * W;
   localparam int PPW  = 2 * W + 1;
   localparam int DETW = 3 * W + 3;
   localparam int DMW  = 3 * W;
   localparam int DW   = sym3_pkg::num_width(DATA_WIDTH, FRAC_BITS);
   localparam int NL   = sym3_pkg::NUM_LANES;
   localparam int NR   = sym3_pkg::NUM_ROWS;

   logic vc_ff, vd_ff, ve_ff;
   logic rdy_c, rdy_d, rdy_e;

   // stage c: split cofactor products
   logic signed [PPW-1:0] ph_in [NR];
   logic signed [PPW-1:0] pl_in [NR];
   logic signed [PPW-1:0] ph_ff [NR];
   logic signed [PPW-1:0] pl_ff [NR];
   logic signed [CW-1:0]  cc_ff [NL];
   // stage d: determinant
   logic signed [DETW-1:0] det_in;
   logic signed [DETW-1:0] det_ff;
   logic signed [CW-1:0]   cd_ff [NL];
   // stage e: magnitudes and dividend
   logic signed [DETW-1:0] det_abs;
   logic [DMW-1:0]         dm_in;
   logic [DW-1:0]          num_in [NL];
   sym3_pkg::sym3_flags_type fl_in;
   logic [DMW-1:0]         dm_ff;
   logic [DW-1:0]          num_ff [NL];
   sym3_pkg::sym3_flags_type fl_ff;

   assign rdy_e    = !ve_ff || out_ready;
   assign rdy_d    = !vd_ff || rdy_e;
   assign rdy_c    = !vc_ff || rdy_d;
   assign in_ready = rdy_c;

   always_comb begin
      logic signed [W:0] c_hi;
      logic signed [W:0] c_lo;
      for (int j = 0; j < NR; j++) begin
         c_hi     = cof[j][CW-1:W];
         c_lo     = {1'b0, cof[j][W-1:0]};
         ph_in[j] = PPW'(brow[j]) * PPW'(c_hi);
         pl_in[j] = PPW'(brow[j]) * PPW'(c_lo);
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < NR; j++) begin
         det_in = det_in + (DETW'(ph_ff[j]) <<< W) + DETW'(pl_ff[j]);
      end
   end

   always_comb begin
      logic signed [CW-1:0] c_abs;
      det_abs        = det_ff[DETW-1] ? -det_ff : det_ff;
      dm_in          = det_abs[DMW-1:0];
      fl_in.singular = (det_ff == '0);
      for (int i = 0; i < NL; i++) begin
         c_abs        = cd_ff[i][CW-1] ? -cd_ff[i] : cd_ff[i];
         fl_in.neg[i] = cd_ff[i][CW-1] ^ det_ff[DETW-1];
         num_in[i]    = (DW'(c_abs[CMW-1:0]) << (2 * FRAC_BITS + 1)) + DW'(dm_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (rdy_c) vc_ff <= in_valid;
         if (rdy_d) vd_ff <= vc_ff;
         if (rdy_e) ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
         cc_ff <= cof;
      end
      if (rdy_d) begin
         det_ff <= det_in;
         cd_ff  <= cc_ff;
      end
      if (rdy_e) begin
         dm_ff  <= dm_in;
         num_ff <= num_in;
         fl_ff  <= fl_in;
      end
   end

   assign out_valid = ve_ff;
   assign num       = num_ff;
   assign dm        = dm_ff;
   assign flags     = fl_ff;

endmodule

### hdl/sym3_div.sv
`timescale 1ns / 1ps

module sym3_div #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [sym3_pkg::num_width(DATA_WIDTH, FRAC_BITS)-1:0] num [sym3_pkg::NUM_LANES],
   input  logic [3*DATA_WIDTH-1:0]       dm,
   input  sym3_pkg::sym3_flags_type      flags_in,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [DATA_WIDTH-1:0]         quo [sym3_pkg::NUM_LANES],
   output logic [sym3_pkg::NUM_LANES-1:0] ovf,
   output sym3_pkg::sym3_flags_type      flags_out
);

   localparam int W   = DATA_WIDTH;
   localparam int DMW = 3 * W;
   localparam int DW  = sym3_pkg::num_width(DATA_WIDTH, FRAC_BITS);
   localparam int NL  = sym3_pkg::NUM_LANES;
   // overflow check, then one quotient bit per stage
   localparam int NS  = W + 1;

   logic [NS-1:0]  v_ff;
   logic [NS-1:0]  rdy;
   logic [DW-1:0]  r_in  [NS][NL];
   logic [DW-1:0]  r_ff  [NS][NL];
   logic [W-1:0]   q_in  [NS][NL];
   logic [W-1:0]   q_ff  [NS][NL];
   logic [NL-1:0]  ovf_in [NS];
   logic [NL-1:0]  ovf_ff [NS];
   logic [DMW-1:0] dm_in [NS];
   logic [DMW-1:0] dm_ff [NS];
   sym3_pkg::sym3_flags_type fl_in [NS];
   sym3_pkg::sym3_flags_type fl_ff [NS];

   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || out_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   always_comb begin
      logic [DW-1:0] dsh;
      logic          take;
      // quotient must stay below 2^W
      dsh      = DW'(dm) << (W + 1);
      dm_in[0] = dm;
      fl_in[0] = flags_in;
      for (int i = 0; i < NL; i++) begin
         r_in[0][i]   = num[i];
         q_in[0][i]   = '0;
         ovf_in[0][i] = (num[i] >= dsh);
      end
      for (int s = 1; s < NS; s++) begin
         dsh       = DW'(dm_ff[s-1]) << (W - s + 1);
         dm_in[s]  = dm_ff[s-1];
         fl_in[s]  = fl_ff[s-1];
         ovf_in[s] = ovf_ff[s-1];
         for (int i = 0; i < NL; i++) begin
            take              = (r_ff[s-1][i] >= dsh);
            r_in[s][i]        = take ? (r_ff[s-1][i] - dsh) : r_ff[s-1][i];
            q_in[s][i]        = q_ff[s-1][i];
            q_in[s][i][W - s] = take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (rdy[s]) begin
            r_ff[s]   <= r_in[s];
            q_ff[s]   <= q_in[s];
            ovf_ff[s] <= ovf_in[s];
            dm_ff[s]  <= dm_in[s];
            fl_ff[s]  <= fl_in[s];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign quo       = q_ff[NS-1];
   assign ovf       = ovf_ff[NS-1];
   assign flags_out = fl_ff[NS-1];

endmodule

### hdl/symmetric_3x3_inverse.sv
`timescale 1ns / 1ps

// Inverse of a symmetric 3x3 matrix by cofactors. A transaction carries the six upper-triangle
// elements (signed, FRAC_BITS fraction bits); the result carries the six distinct inverse
// elements, each cofactor / determinant rounded to nearest (halves away from zero) and clipped
// to the signed DATA_WIDTH range, with saturated set when any element was clipped. The
// determinant is exact; when it is zero the identity comes back with singular set. The block
// takes one transaction per cycle when not stalled: two stages form the cofactors, three the
// determinant and the dividend, the divider uses DATA_WIDTH + 1 stages, an overflow check and
// then one quotient bit per stage, for all six elements in parallel, and one stage rounds and
// clips into the output register. Every stage moves on its own, so bubbles close up and
// transactions keep entering while a result waits on rsp_stall.

module symmetric_3x3_inverse #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_b_00,
   input  logic signed [DATA_WIDTH-1:0] req_b_01,
   input  logic signed [DATA_WIDTH-1:0] req_b_02,
   input  logic signed [DATA_WIDTH-1:0] req_b_11,
   input  logic signed [DATA_WIDTH-1:0] req_b_12,
   input  logic signed [DATA_WIDTH-1:0] req_b_22,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_00,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_01,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_02,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_11,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_12,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_22,
   output logic                         rsp_singular,
   output logic                         rsp_saturated
);

   localparam int W   = DATA_WIDTH;
   localparam int DW  = sym3_pkg::num_width(DATA_WIDTH, FRAC_BITS);
   localparam int NL  = sym3_pkg::NUM_LANES;
   localparam int NR  = sym3_pkg::NUM_ROWS;

   // clip limits and the identity diagonal
   localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MAX_NEG  = {1'b1, {(W-1){1'b0}}};
   localparam logic         ONE_FITS = (FRAC_BITS < DATA_WIDTH - 1);
   localparam logic [W-1:0] DIAG     = ONE_FITS ? (DATA_WIDTH'(1) << FRAC_BITS) : MAX_POS;

   // cofactor stages
   logic                 cof_ready, cof_valid;
   logic signed [2*W:0]  cof [NL];
   logic signed [W-1:0]  brow [NR];

   // determinant stages
   logic                 det_ready, det_valid;
   logic [DW-1:0]        num [NL];
   logic [3*W-1:0]       dm;
   sym3_pkg::sym3_flags_type det_flags;

   // divider
   logic                 div_ready, div_valid;
   logic [W-1:0]         quo [NL];
   logic [NL-1:0]        ovf;
   sym3_pkg::sym3_flags_type div_flags;

   // output register
   logic                 out_ready;
   logic                 rsp_valid_ff;
   logic [W-1:0]         inv_in [NL];
   logic [W-1:0]         inv_ff [NL];
   logic                 sing_in, sing_ff;
   logic                 sat_in, sat_ff;

   sym3_cof #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (cof_ready),
      .b_00      (req_b_00),
      .b_01      (req_b_01),
      .b_02      (req_b_02),
      .b_11      (req_b_11),
      .b_12      (req_b_12),
      .b_22      (req_b_22),
      .out_valid (cof_valid),
      .out_ready (det_ready),
      .cof       (cof),
      .brow      (brow)
   );

   sym3_det #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (det_ready),
      .cof       (cof),
      .brow      (brow),
      .out_valid (det_valid),
      .out_ready (div_ready),
      .num       (num),
      .dm        (dm),
      .flags     (det_flags)
   );

   sym3_div #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_valid),
      .in_ready  (div_ready),
      .num       (num),
      .dm        (dm),
      .flags_in  (det_flags),
      .out_valid (div_valid),
      .out_ready (out_ready),
      .quo       (quo),
      .ovf       (ovf),
      .flags_out (div_flags)
   );

   // request side stalls only when the first stage holds a transaction that cannot move
   assign req_stall = !cof_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // sign, clip and the singular override
   always_comb begin
      logic [W-1:0] lim;
      logic         clip;
      sat_in  = 1'b0;
      sing_in = div_flags.singular;
      for (int i = 0; i < NL; i++) begin
         lim       = div_flags.neg[i] ? MAX_NEG : MAX_POS;
         clip      = ovf[i] || (quo[i] > lim);
         sat_in    = sat_in | clip;
         inv_in[i] = clip ? lim : (div_flags.neg[i] ? (~quo[i] + 1'b1) : quo[i]);
      end
      if (div_flags.singular) begin
         for (int i = 0; i < NL; i++) begin
            inv_in[i] = '0;
         end
         inv_in[sym3_pkg::LANE_00] = DIAG;
         inv_in[sym3_pkg::LANE_11] = DIAG;
         inv_in[sym3_pkg::LANE_22] = DIAG;
         sat_in                    = !ONE_FITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         inv_ff  <= inv_in;
         sing_ff <= sing_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inv_00    = inv_ff[sym3_pkg::LANE_00];
   assign rsp_inv_01    = inv_ff[sym3_pkg::LANE_01];
   assign rsp_inv_02    = inv_ff[sym3_pkg::LANE_02];
   assign rsp_inv_11    = inv_ff[sym3_pkg::LANE_11];
   assign rsp_inv_12    = inv_ff[sym3_pkg::LANE_12];
   assign rsp_inv_22    = inv_ff[sym3_pkg::LANE_22];
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;

   // a singular result is the identity: off-diagonal elements are zero
   a_singular_offdiag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_inv_01 == '0 && rsp_inv_02 == '0 && rsp_inv_12 == '0)
      else $error("singular transaction with nonzero off-diagonal element");

   // when the identity diagonal fits the range, a singular result is never flagged saturated
   a_singular_nosat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular && ONE_FITS |-> !rsp_saturated)
      else $error("singular transaction flagged as saturated");

   // nothing comes out in the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the request side is held off only while the output register is blocked and the divider's last stage is full
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !out_ready && div_valid)
      else $error("request stalled with room in the pipeline");

endmodule
